FILE: rtl/core/dtti_pkg.sv
`timescale 1ns / 1ps

package dtti_pkg;

  // Field widths
  localparam int TIME_W = 64;
  localparam int FREQ_W = 35;
  localparam int NS_W   = 30;

  // Constants of the conversion
  localparam logic [TIME_W-1:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [TIME_W-1:0] ALL_ONES   = {TIME_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 35'd18446744073;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 35'd100000000;

  // Default timer count width
  localparam int INITVAL_BITS_DEF = 30;

endpackage

FILE: rtl/core/dtti_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, payload rides along.
module dtti_div #(
  parameter int N = 64,
  parameter int D = 35,
  parameter int P = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  input  logic [P-1:0] in_pay,
  output logic         out_valid,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder,
  output logic [P-1:0] out_pay
);

  logic [N-1:0] valid_r;
  logic [D-1:0] rem_r [N];
  logic [N-1:0] quo_r [N];
  logic [N-1:0] dvd_r [N];
  logic [P-1:0] pay_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic         v_in;
    logic [D-1:0] rem_in;
    logic [N-1:0] quo_in;
    logic [N-1:0] dvd_in;
    logic [P-1:0] pay_in;
    logic [D:0]   part;
    logic [D:0]   diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend;
      assign pay_in = in_pay;
    end else begin : g_next
      assign v_in   = valid_r[k-1];
      assign rem_in = rem_r[k-1];
      assign quo_in = quo_r[k-1];
      assign dvd_in = dvd_r[k-1];
      assign pay_in = pay_r[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign part = {rem_in, dvd_in[N-1-k]};
    assign diff = part - {1'b0, divisor};
    assign ge   = (part >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[D-1:0] : part[D-1:0];
        quo_r[k] <= {quo_in[N-2:0], ge};
        dvd_r[k] <= dvd_in;
        pay_r[k] <= pay_in;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign quotient  = quo_r[N-1];
  assign remainder = rem_r[N-1];
  assign out_pay   = pay_r[N-1];

endmodule

// Divide a 64-bit value by 1e9 in three stages: 1e9 = 2^9 * 5^9, so the low
// nine bits pass through and the rest is divided by 5^9 with an exact
// reciprocal multiply (split in 32-bit pieces), then the remainder is rebuilt.
module dtti_div1e9 #(
  parameter int P = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [dtti_pkg::TIME_W-1:0] dividend,
  input  logic [P-1:0]                in_pay,
  output logic                        out_valid,
  output logic [dtti_pkg::TIME_W-1:0] quotient,
  output logic [dtti_pkg::NS_W-1:0]   remainder,
  output logic [P-1:0]                out_pay
);

  localparam int YW = 55;   // dividend without the low nine bits
  localparam int QW = 35;   // quotient fits 35 bits
  localparam int SH = 76;   // YW + ceil(log2(5^9))
  localparam logic [76:0] D5_W    = 77'(dtti_pkg::NS_PER_SEC >> 9);
  localparam logic [76:0] RECIP_W = ((77'd1 << SH) + D5_W - 77'd1) / D5_W;
  localparam logic [55:0] RECIP   = RECIP_W[55:0];
  localparam logic [31:0] RCP_LO  = RECIP[31:0];
  localparam logic [23:0] RCP_HI  = RECIP[55:32];
  localparam logic [54:0] D5      = D5_W[54:0];

  // partial products of y * RECIP
  logic [YW-1:0] y;
  logic [63:0]   pp_ll_nxt;
  logic [55:0]   pp_lh_nxt;
  logic [54:0]   pp_hl_nxt;
  logic [46:0]   pp_hh_nxt;
  logic          a_valid_r;
  logic [63:0]   a_ll_r;
  logic [55:0]   a_lh_r;
  logic [54:0]   a_hl_r;
  logic [46:0]   a_hh_r;
  logic [YW-1:0] a_y_r;
  logic [8:0]    a_lo_r;
  logic [P-1:0]  a_pay_r;

  assign y         = dividend[63:9];
  assign pp_ll_nxt = {32'd0, y[31:0]} * {32'd0, RCP_LO};
  assign pp_lh_nxt = {24'd0, y[31:0]} * {32'd0, RCP_HI};
  assign pp_hl_nxt = {32'd0, y[54:32]} * {23'd0, RCP_LO};
  assign pp_hh_nxt = {24'd0, y[54:32]} * {23'd0, RCP_HI};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ll_r  <= pp_ll_nxt;
      a_lh_r  <= pp_lh_nxt;
      a_hl_r  <= pp_hl_nxt;
      a_hh_r  <= pp_hh_nxt;
      a_y_r   <= y;
      a_lo_r  <= dividend[8:0];
      a_pay_r <= in_pay;
    end
  end

  // sum partial products, keep the quotient bits
  logic [111:0]  full_nxt;
  logic          b_valid_r;
  logic [QW-1:0] b_q_r;
  logic [YW-1:0] b_y_r;
  logic [8:0]    b_lo_r;
  logic [P-1:0]  b_pay_r;

  assign full_nxt = 112'(a_ll_r) + (112'(a_lh_r) << 32) + (112'(a_hl_r) << 32)
                  + (112'(a_hh_r) << 64);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_q_r   <= full_nxt[SH+QW-1:SH];
      b_y_r   <= a_y_r;
      b_lo_r  <= a_lo_r;
      b_pay_r <= a_pay_r;
    end
  end

  // remainder from quotient
  logic [YW-1:0] r_nxt;
  logic          c_valid_r;
  logic [QW-1:0] c_q_r;
  logic [dtti_pkg::NS_W-1:0] c_rem_r;
  logic [P-1:0]  c_pay_r;

  assign r_nxt = b_y_r - ({20'd0, b_q_r} * D5);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q_r   <= b_q_r;
      c_rem_r <= {r_nxt[20:0], b_lo_r};
      c_pay_r <= b_pay_r;
    end
  end

  assign out_valid = c_valid_r;
  assign quotient  = {29'd0, c_q_r};
  assign remainder = c_rem_r;
  assign out_pay   = c_pay_r;

endmodule

FILE: rtl/core/dtti_t2n.sv
`timescale 1ns / 1ps

// Counter ticks to nanoseconds: seconds plus scaled remainder, saturating.
module dtti_t2n (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        armed,
  input  logic [dtti_pkg::TIME_W-1:0] deadline_ns,
  input  logic [dtti_pkg::TIME_W-1:0] counter_ticks,
  input  logic [dtti_pkg::FREQ_W-1:0] freq,
  output logic                        out_valid,
  output logic                        out_armed,
  output logic [dtti_pkg::TIME_W-1:0] out_deadline,
  output logic [dtti_pkg::TIME_W-1:0] out_now
);

  localparam int TW = dtti_pkg::TIME_W;
  localparam int FW = dtti_pkg::FREQ_W;
  localparam int PA = TW + 1;
  localparam int PC = TW + 1 + 1 + TW;

  logic          a_valid;
  logic [TW-1:0] a_sec;
  logic [FW-1:0] a_rem;
  logic [PA-1:0] a_pay;

  // seconds and remainder
  dtti_div #(.N(TW), .D(FW), .P(PA)) u_div_sec (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .dividend(counter_ticks), .divisor(freq),
    .in_pay({armed, deadline_ns}),
    .out_valid(a_valid), .quotient(a_sec), .remainder(a_rem), .out_pay(a_pay)
  );

  // scale by 1e9
  logic [TW:0]   secns_full;
  logic [TW:0]   remns_full;
  logic          b_valid_r;
  logic          b_ovf_r;
  logic [TW-1:0] b_secns_r;
  logic [TW:0]   b_remns_r;
  logic [PA-1:0] b_pay_r;

  assign secns_full = (TW+1)'(a_sec[FW-1:0]) * (TW+1)'(dtti_pkg::NS_PER_SEC);
  assign remns_full = (TW+1)'(a_rem) * (TW+1)'(dtti_pkg::NS_PER_SEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ovf_r   <= (a_sec > TW'(dtti_pkg::FREQ_MAX));
      b_secns_r <= secns_full[TW-1:0];
      b_remns_r <= remns_full;
      b_pay_r   <= a_pay;
    end
  end

  logic          c_valid;
  logic [TW:0]   c_frac;
  logic [FW-1:0] c_rem;
  logic [PC-1:0] c_pay;

  // fractional nanoseconds
  dtti_div #(.N(TW+1), .D(FW), .P(PC)) u_div_frac (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b_valid_r), .dividend(b_remns_r), .divisor(freq),
    .in_pay({b_pay_r, b_ovf_r, b_secns_r}),
    .out_valid(c_valid), .quotient(c_frac), .remainder(c_rem), .out_pay(c_pay)
  );

  // saturating sum; remainder of this division is not needed
  logic [TW:0] sum;
  logic        d_valid_r;
  logic        d_armed_r;
  logic [TW-1:0] d_deadline_r;
  logic [TW-1:0] d_now_r;
  logic        unused_rem;

  assign unused_rem = ^c_rem;
  assign sum = {1'b0, c_pay[TW-1:0]} + {1'b0, c_frac[TW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en) begin
      d_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_armed_r    <= c_pay[PC-1];
      d_deadline_r <= c_pay[PC-2 -: TW];
      d_now_r      <= (c_pay[TW] || sum[TW] || unused_rem & 1'b0)
                      ? dtti_pkg::ALL_ONES : sum[TW-1:0];
    end
  end

  assign out_valid    = d_valid_r;
  assign out_armed    = d_armed_r;
  assign out_deadline = d_deadline_r;
  assign out_now      = d_now_r;

endmodule

FILE: rtl/core/dtti_n2t.sv
`timescale 1ns / 1ps

// Distance to deadline in ns, back to ticks rounding up, then clamp.
module dtti_n2t #(
  parameter int INITVAL_BITS = dtti_pkg::INITVAL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        armed,
  input  logic [dtti_pkg::TIME_W-1:0] deadline_ns,
  input  logic [dtti_pkg::TIME_W-1:0] now_ns,
  input  logic [dtti_pkg::FREQ_W-1:0] freq,
  output logic                        out_valid,
  output logic [dtti_pkg::TIME_W-1:0] out_now,
  output logic                        out_enable,
  output logic [INITVAL_BITS-1:0]     out_initval
);

  localparam int TW = dtti_pkg::TIME_W;
  localparam int FW = dtti_pkg::FREQ_W;
  localparam int NW = dtti_pkg::NS_W;
  localparam int PF = TW + 1;
  localparam int PH = TW + 1 + 1 + TW;
  localparam logic [TW-1:0] TOP = TW'((65'd1 << INITVAL_BITS) - 65'd1);

  // non-negative distance
  logic          e_valid_r;
  logic          e_armed_r;
  logic [TW-1:0] e_now_r;
  logic [TW-1:0] e_delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (en) begin
      e_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_armed_r <= armed;
      e_now_r   <= now_ns;
      e_delta_r <= (deadline_ns > now_ns) ? deadline_ns - now_ns : '0;
    end
  end

  // whole seconds and ns remainder
  logic          f_valid;
  logic [TW-1:0] f_sec;
  logic [NW-1:0] f_rem;
  logic [PF-1:0] f_pay;

  dtti_div1e9 #(.P(PF)) u_div_sec (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(e_valid_r), .dividend(e_delta_r),
    .in_pay({e_armed_r, e_now_r}),
    .out_valid(f_valid), .quotient(f_sec), .remainder(f_rem), .out_pay(f_pay)
  );

  // scale by frequency; seconds fit in FW bits
  logic [TW+5:0] secf_full;
  logic [TW:0]   prod_full;
  logic          g_valid_r;
  logic          g_ovf_r;
  logic [TW-1:0] g_secf_r;
  logic [TW-1:0] g_prod_r;
  logic [PF-1:0] g_pay_r;

  assign secf_full = (TW+6)'(f_sec[FW-1:0]) * (TW+6)'(freq);
  assign prod_full = (TW+1)'(f_rem) * (TW+1)'(freq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (en) begin
      g_valid_r <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ovf_r  <= |secf_full[TW+5:TW];
      g_secf_r <= secf_full[TW-1:0];
      g_prod_r <= prod_full[TW-1:0];
      g_pay_r  <= f_pay;
    end
  end

  // sub-second ticks
  logic          h_valid;
  logic [TW-1:0] h_part;
  logic [NW-1:0] h_rem;
  logic [PH-1:0] h_pay;

  dtti_div1e9 #(.P(PH)) u_div_part (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(g_valid_r), .dividend(g_prod_r),
    .in_pay({g_pay_r, g_ovf_r, g_secf_r}),
    .out_valid(h_valid), .quotient(h_part), .remainder(h_rem), .out_pay(h_pay)
  );

  // round up, saturate, clamp
  logic [TW-1:0] part_up;
  logic [TW:0]   sum;
  logic [TW-1:0] ticks;
  logic [TW-1:0] clamped;
  logic          i_valid_r;
  logic [TW-1:0] i_now_r;
  logic          i_enable_r;
  logic [INITVAL_BITS-1:0] i_initval_r;

  assign part_up = h_part + TW'(h_rem != '0);
  assign sum     = {1'b0, h_pay[TW-1:0]} + {1'b0, part_up};
  assign ticks   = (h_pay[TW] || sum[TW]) ? dtti_pkg::ALL_ONES : sum[TW-1:0];
  assign clamped = (ticks == '0) ? TW'(1) : ((ticks > TOP) ? TOP : ticks);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
    end else if (en) begin
      i_valid_r <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_now_r     <= h_pay[PH-2 -: TW];
      i_enable_r  <= h_pay[PH-1];
      i_initval_r <= h_pay[PH-1] ? clamped[INITVAL_BITS-1:0] : '0;
    end
  end

  assign out_valid   = i_valid_r;
  assign out_now     = i_now_r;
  assign out_enable  = i_enable_r;
  assign out_initval = i_initval_r;

endmodule

FILE: rtl/core/deadline_to_timer_initval_core.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields (tdata from bit 0 up)
// in_     | in  | armed, deadline_ns[64], counter_ticks[64], zero pad to 136
// out_    | out | now_ns[64], timer_enable, initval[INITVAL_BITS], clear_pending, pad
// cfg_    | in  | tick_freq[35], written when cfg_wen is high
//
// One word accepted per cycle, back to back, unless the output stalls; each result
// word passes the two bit-per-stage dividers by the frequency (64 and 65 stages),
// and the two divisions by 1e9, which are 3-stage reciprocal multiplies.
// Reset (rst_n low, synchronous) clears all valid bits and loads 100 MHz.
// The whole pipeline holds while the output word waits, so in_tready drops with it.
module deadline_to_timer_initval_core #(
  parameter int INITVAL_BITS = dtti_pkg::INITVAL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,     // armed, deadline_ns, counter_ticks
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [((66+INITVAL_BITS+7)/8)*8-1:0] out_tdata,
                                     // now_ns, timer_enable, initval, clear_pending
  input  logic         cfg_wen,
  input  logic [dtti_pkg::FREQ_W-1:0] cfg_wdata  // tick_freq
);

  localparam int TW    = dtti_pkg::TIME_W;
  localparam int FW    = dtti_pkg::FREQ_W;
  localparam int OUT_W = ((66 + INITVAL_BITS + 7) / 8) * 8;

  // effective frequency: zero reads as 1 Hz, capped at the max
  logic [FW-1:0] freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= dtti_pkg::FREQ_RESET;
    end else if (cfg_wen) begin
      if (cfg_wdata == '0) begin
        freq_r <= FW'(1);
      end else if (cfg_wdata > dtti_pkg::FREQ_MAX) begin
        freq_r <= dtti_pkg::FREQ_MAX;
      end else begin
        freq_r <= cfg_wdata;
      end
    end
  end

  // pipeline advance
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic          t_valid;
  logic          t_armed;
  logic [TW-1:0] t_deadline;
  logic [TW-1:0] t_now;

  dtti_t2n u_t2n (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid && en),
    .armed(in_tdata[0]),
    .deadline_ns(in_tdata[64:1]),
    .counter_ticks(in_tdata[128:65]),
    .freq(freq_r),
    .out_valid(t_valid), .out_armed(t_armed),
    .out_deadline(t_deadline), .out_now(t_now)
  );

  logic                    n_valid;
  logic [TW-1:0]           n_now;
  logic                    n_enable;
  logic [INITVAL_BITS-1:0] n_initval;

  dtti_n2t #(.INITVAL_BITS(INITVAL_BITS)) u_n2t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(t_valid), .armed(t_armed),
    .deadline_ns(t_deadline), .now_ns(t_now), .freq(freq_r),
    .out_valid(n_valid), .out_now(n_now),
    .out_enable(n_enable), .out_initval(n_initval)
  );

  // output register
  logic [OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= OUT_W'({1'b1, n_initval, n_enable, n_now});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/dtti_chk.sv
`timescale 1ns / 1ps

// Port-level checks of the timer value stream.
module dtti_chk #(
  parameter int INITVAL_BITS = dtti_pkg::INITVAL_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((66+INITVAL_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int EN_B = 64;
  localparam int IV_L = 65;
  localparam int CP_B = 65 + INITVAL_BITS;

  // stalled word stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped or changed under stall");

  // clear request always set
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CP_B])
    else $error("clear_pending low");

  // disarmed word carries zero count
  a_dis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[EN_B] |-> out_tdata[CP_B-1:IV_L] == '0)
    else $error("disarmed word with nonzero initval");

  // armed word never carries zero count
  a_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[EN_B] |-> out_tdata[CP_B-1:IV_L] != '0)
    else $error("armed word with zero initval");

endmodule

bind deadline_to_timer_initval_core dtti_chk #(.INITVAL_BITS(INITVAL_BITS)) u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

FILE: dv/deadline_timer_checker.sv
`timescale 1ns / 1ps

module deadline_timer_checker #(
  parameter int INITVAL_BITS = dtti_pkg::INITVAL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [((66+INITVAL_BITS+7)/8)*8-1:0] out_tdata,
  input  logic         cfg_wen,
  input  logic [dtti_pkg::FREQ_W-1:0] cfg_wdata,
  output int           fail_count,
  output int           words_pending
);
  import dtti_pkg::*;

  typedef struct packed {
    logic                    clear_pending;
    logic [INITVAL_BITS-1:0] initval;
    logic                    timer_enable;
    logic [TIME_W-1:0]       now_ns;
  } timer_word_t;

  logic [FREQ_W-1:0] freq_reg;
  timer_word_t       timer_words_due[$];

  // Expected timer word for one request word under a given frequency
  function automatic timer_word_t timer_word_for(logic armed, logic [63:0] deadline,
                                                 logic [63:0] ticks, logic [FREQ_W-1:0] freq);
    logic [127:0] f, sec, rem, prod, part, sum, delta, dsec, drem, cnt, top;
    timer_word_t  w;
    f = (freq == '0) ? 128'd1 : (freq > FREQ_MAX ? 128'(FREQ_MAX) : 128'(freq));
    // counter ticks to nanoseconds, saturating
    sec = ticks / f;
    rem = ticks % f;
    if (sec > 128'(ALL_ONES) / 128'(NS_PER_SEC)) sum = 128'(ALL_ONES);
    else begin
      sum = sec * NS_PER_SEC + (rem * NS_PER_SEC) / f;
      if (sum > 128'(ALL_ONES)) sum = 128'(ALL_ONES);
    end
    w.now_ns        = sum[63:0];
    w.timer_enable  = armed;
    w.clear_pending = 1'b1;
    w.initval       = '0;
    if (armed) begin
      delta = (deadline > w.now_ns) ? 128'(deadline - w.now_ns) : 128'd0;
      dsec  = delta / NS_PER_SEC;
      drem  = delta % NS_PER_SEC;
      // nanoseconds back to ticks, rounding up, saturating
      if (dsec > 128'(ALL_ONES) / f) cnt = 128'(ALL_ONES);
      else begin
        prod = drem * f;
        part = prod / NS_PER_SEC + ((prod % NS_PER_SEC) != 0 ? 128'd1 : 128'd0);
        cnt  = dsec * f + part;
        if (cnt > 128'(ALL_ONES)) cnt = 128'(ALL_ONES);
      end
      top = (128'd1 << INITVAL_BITS) - 1;
      if (cnt == 0) cnt = 128'd1;
      else if (cnt > top) cnt = top;
      w.initval = cnt[INITVAL_BITS-1:0];
    end
    return w;
  endfunction

  task automatic report_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, field, exp_v, act_v);
    end
  endtask

  assign words_pending = timer_words_due.size();

  // Watch all three channels
  always @(posedge clk) begin
    timer_word_t exp_w, act_w;
    if (!rst_n) begin
      freq_reg <= FREQ_RESET;
      timer_words_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        timer_words_due.push_back(timer_word_for(in_tdata[0], in_tdata[64:1],
                                                 in_tdata[128:65], freq_reg));
      if (out_tvalid && out_tready) begin
        act_w = out_tdata[66+INITVAL_BITS-1:0];
        if (timer_words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t unexpected output word %0h", $realtime, act_w);
        end else begin
          exp_w = timer_words_due.pop_front();
          report_field("now_ns", exp_w.now_ns, act_w.now_ns);
          report_field("timer_enable", exp_w.timer_enable, act_w.timer_enable);
          report_field("initval", exp_w.initval, act_w.initval);
          report_field("clear_pending", exp_w.clear_pending, act_w.clear_pending);
        end
      end
      if (cfg_wen) freq_reg <= cfg_wdata;
    end
  end

endmodule

FILE: dv/tb_deadline_to_timer_initval_core.sv
`timescale 1ns / 1ps

module tb_deadline_to_timer_initval_core;
  import dtti_pkg::*;

  localparam int IVB   = INITVAL_BITS_DEF;
  localparam int OUT_W = ((66+IVB+7)/8)*8;
  localparam int DRAIN = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [135:0]      in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_wen = 1'b0;
  logic [FREQ_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                words_pending;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  deadline_to_timer_initval_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  deadline_timer_checker #(.INITVAL_BITS(IVB)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // Result side: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_req != hold_seen) begin
      hold_cnt = 600;
      hold_seen = hold_req;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Offer one request word and wait until it is taken
  task automatic send_word(logic armed, logic [63:0] deadline, logic [63:0] ticks);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {7'd0, ticks, deadline, armed};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic write_freq(logic [FREQ_W-1:0] freq);
    cfg_wdata <= freq;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_time();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    w = $urandom_range(0, 64);
    return (w == 0) ? 64'd0 : v >> (64 - w);
  endfunction

  initial begin
    logic [FREQ_W-1:0] freqs [7];
    logic [63:0]       ticks;
    freqs = '{FREQ_RESET, 35'd1, 35'd0, FREQ_MAX, 35'h7FFFFFFFF, 35'd1000000000,
              35'd24000000};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset frequency
    send_word(1'b0, 64'd0, 64'd0);
    send_word(1'b1, 64'd0, 64'd0);
    send_word(1'b1, ALL_ONES, 64'd0);
    send_word(1'b1, 64'd0, ALL_ONES);
    send_word(1'b1, ALL_ONES, ALL_ONES);
    send_word(1'b0, ALL_ONES, ALL_ONES);
    send_word(1'b1, 64'd1000000000, 64'd0);
    send_word(1'b1, 64'd1, 64'd0);
    send_word(1'b1, 64'd10, 64'd0);
    send_word(1'b1, 64'd15, 64'd0);
    send_word(1'b1, 64'd100, 64'd5);
    send_word(1'b1, 64'd1000, 64'd200);
    send_word(1'b0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    wait_drained();

    // Random phases, one per frequency setting
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) write_freq(ph == 6 ? 35'($urandom_range(1, 2000000000)) : freqs[ph]);
      if (ph == 2) hold_req++;
      for (int i = 0; i < 240; i++) begin
        case (i / 80)
          0: begin tx_idle_pct = 10; rx_idle_pct = 83; end
          1: begin tx_idle_pct = 83; rx_idle_pct = 10; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        if ($urandom_range(0, 3) == 0) ticks = {$urandom, $urandom};
        else ticks = rand_time() >> $urandom_range(0, 40);
        send_word($urandom_range(0, 7) != 0,
                  ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : rand_time(), ticks);
      end
      wait_drained();
    end

    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: deadline_to_timer_initval_core.f
rtl/core/dtti_pkg.sv
rtl/core/dtti_div.sv
rtl/core/dtti_t2n.sv
rtl/core/dtti_n2t.sv
rtl/core/deadline_to_timer_initval_core.sv
rtl/core/dtti_chk.sv
dv/deadline_timer_checker.sv
dv/tb_deadline_to_timer_initval_core.sv
